// ===== rtl/itaf_pkg.sv =====
// Package for the integer to ASCII formatter.
// Holds the sizes, the request and character types, the state codes and the digit mapping.
// No dependencies.
package itaf_pkg;

    localparam int MAX_PAD    = 62;
    localparam int MAX_DIGITS = 20;
    localparam int VAL_W      = 64;
    localparam int SHORT_W    = 32;
    localparam int PAD_IN_W   = 7;
    localparam int CHAR_W     = 8;
    localparam int DIG_W      = 4 * MAX_DIGITS;
    localparam int PAD_W      = $clog2(MAX_PAD + 1);
    localparam int ND_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W      = $clog2(VAL_W);
    localparam int CMP_W      = (PAD_W > ND_W) ? PAD_W : ND_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_X     = 2'd1;
    localparam logic [1:0] PRE_ZERO  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic                is_long;
        logic                base_hex;
        logic                upper_case;
        logic                hex_prefix;
        logic [PAD_IN_W-1:0] pad_width;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            if (d < 4'd10) begin
                digit_char = CHAR_ZERO + {4'b0000, d};
            end else begin
                digit_char = base + {4'b0000, d} - 8'd10;
            end
        end
    endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// A request is taken in idle and converted bit-serially over its 32 or 64 bits, by the
// shift-and-add-3 loop in decimal and by plain shifts in hex; leading zeros are scanned off,
// then prefix, padding and digits go out, one character per cycle when the output does not
// stall. One request at a time: the input stalls until the last character is put out.
// Reset: i_rst_n is synchronous and active low; it returns the block to idle with no output.
// Depends on itaf_pkg.
module integer_to_ascii_formatter import itaf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_state            r_state, n_state;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [DIG_W-1:0]  r_dig, n_dig;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_hex, n_hex;
    logic              r_upper, n_upper;
    logic [1:0]        r_pre, n_pre;
    logic [PAD_W-1:0]  r_pad_sat, n_pad_sat;
    logic [PAD_W-1:0]  r_pad, n_pad;
    logic [ND_W-1:0]   r_nd, n_nd;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [DIG_W-1:0]  adj;
    logic [3:0]        top;
    logic              slot_free;
    logic              is_last;
    logic [CMP_W-1:0]  pad_ext, nd_ext;

    assign top       = r_dig[DIG_W-1 -: 4];
    assign slot_free = !r_out_valid || !i_out_stall;
    assign is_last   = (r_pre == PRE_NONE) && (r_pad == '0) && (r_nd == ND_W'(1));
    assign pad_ext   = CMP_W'(r_pad_sat);
    assign nd_ext    = CMP_W'(r_nd);

    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (!r_hex && (r_dig[4*k +: 4] >= 4'd5)) begin
                adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_dig       = r_dig;
        n_bit       = r_bit;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_pre       = r_pre;
        n_pad_sat   = r_pad_sat;
        n_pad       = r_pad;
        n_nd        = r_nd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.is_long) begin
                        n_val = i_in_data.value;
                        n_bit = BIT_W'(VAL_W - 1);
                    end else begin
                        n_val = {i_in_data.value[SHORT_W-1:0], {(VAL_W-SHORT_W){1'b0}}};
                        n_bit = BIT_W'(SHORT_W - 1);
                    end
                    n_dig   = '0;
                    n_hex   = i_in_data.base_hex;
                    n_upper = i_in_data.upper_case;
                    n_pre   = (i_in_data.base_hex && i_in_data.hex_prefix) ? PRE_ZERO : PRE_NONE;
                    if (i_in_data.pad_width > PAD_IN_W'(MAX_PAD)) begin
                        n_pad_sat = PAD_W'(MAX_PAD);
                    end else begin
                        n_pad_sat = i_in_data.pad_width[PAD_W-1:0];
                    end
                    n_nd    = ND_W'(MAX_DIGITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_dig = {adj[DIG_W-2:0], r_val[VAL_W-1]};
                n_val = {r_val[VAL_W-2:0], 1'b0};
                if (r_bit == '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_SCAN: begin
                if ((top == 4'd0) && (r_nd != ND_W'(1))) begin
                    n_dig = {r_dig[DIG_W-5:0], 4'd0};
                    n_nd  = r_nd - ND_W'(1);
                end else begin
                    if (pad_ext > nd_ext) begin
                        n_pad = PAD_W'(pad_ext - nd_ext);
                    end else begin
                        n_pad = '0;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out.last   = is_last;
                    if (r_pre == PRE_ZERO) begin
                        n_out.out_char = CHAR_ZERO;
                        n_pre          = PRE_X;
                    end else if (r_pre == PRE_X) begin
                        n_out.out_char = CHAR_X;
                        n_pre          = PRE_NONE;
                    end else if (r_pad != '0) begin
                        n_out.out_char = CHAR_ZERO;
                        n_pad          = r_pad - PAD_W'(1);
                    end else begin
                        n_out.out_char = digit_char(top, r_upper);
                        n_dig          = {r_dig[DIG_W-5:0], 4'd0};
                        n_nd           = r_nd - ND_W'(1);
                        if (is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_val     <= n_val;
        r_dig     <= n_dig;
        r_bit     <= n_bit;
        r_hex     <= n_hex;
        r_upper   <= n_upper;
        r_pre     <= n_pre;
        r_pad_sat <= n_pad_sat;
        r_pad     <= n_pad;
        r_nd      <= n_nd;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/itaf_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to its top level.
// Depends on itaf_pkg and integer_to_ascii_formatter.
module itaf_checker import itaf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("Reset did not clear the output and the input stall.");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A request was taken but the input side did not stall.");

    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_stall) |-> o_out_data.last)
        else $error("A character other than the last is pending while idle.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("A stalled character changed or was dropped.");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);
